// ----- rtl/mfd_pkg.sv -----
// Shared types and constants for the meter frame deframer.
package mfd_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
    localparam logic [7:0] SCRAMBLE_BYTE = 8'h33;

    localparam logic [7:0] HEAD_RESET    = 8'h68;
    localparam logic [7:0] TAIL_RESET    = 8'h16;
    localparam logic [7:0] MAX_PAY_RESET = 8'd200;

    localparam int unsigned ADDR_BYTES = 6;
    localparam int unsigned PADDR_W    = 4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_HEAD    = 2'd0;
    localparam logic [1:0] REG_TAIL    = 2'd1;
    localparam logic [1:0] REG_MAX_PAY = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_HEAD2 = 3'd2,
        PH_CTRL  = 3'd3,
        PH_LEN   = 3'd4,
        PH_PAY   = 3'd5,
        PH_SUM   = 3'd6,
        PH_TAIL  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_HEAD  = 3'd1,
        ERR_TOO_LONG  = 3'd2,
        ERR_CHECKSUM  = 3'd3,
        ERR_BAD_TAIL  = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] max_payload;
    } t_cfg;

    typedef struct packed {
        t_kind       result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [47:0] meter_address;
        logic [7:0]  control_code;
        logic [7:0]  payload_length;
        t_err        error_code;
        logic        last_of_frame;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_push;

endpackage

// ----- rtl/mfd_if.sv -----
// Channel interfaces: received bytes in, decoded result items out.
interface mfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [47:0] meter_address;
    logic [7:0]  control_code;
    logic [7:0]  payload_length;
    logic [2:0]  error_code;
    logic        last_of_frame;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output meter_address, output control_code, output payload_length,
        output error_code, output last_of_frame, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input meter_address, input control_code, input payload_length,
        input error_code, input last_of_frame, output ready
    );
endinterface

// ----- rtl/mfd_parser.sv -----
// Frame parsing state machine: one received byte per accepted item.
module mfd_parser
    import mfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_accept,
    input  logic [7:0] i_rx_byte,
    output t_res_push o_push
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_sum, n_sum;
    logic [47:0] r_addr, n_addr;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_len, n_len;

    logic [7:0]  count_inc;
    logic [47:0] addr_lane;

    assign count_inc = r_count + 8'd1;
    // Address bytes arrive least significant first; the count selects the lane.
    assign addr_lane = {40'd0, i_rx_byte} << {r_count[2:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_sum   <= '0;
            r_addr  <= '0;
            r_ctrl  <= '0;
            r_len   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_addr  <= n_addr;
            r_ctrl  <= n_ctrl;
            r_len   <= n_len;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_sum   = r_sum;
        n_addr  = r_addr;
        n_ctrl  = r_ctrl;
        n_len   = r_len;

        o_push.valid                = 1'b0;
        o_push.data.result_kind     = KIND_PAYLOAD;
        o_push.data.payload_byte    = '0;
        o_push.data.payload_index   = '0;
        o_push.data.meter_address   = r_addr;
        o_push.data.control_code    = r_ctrl;
        o_push.data.payload_length  = r_len;
        o_push.data.error_code      = ERR_NONE;
        o_push.data.last_of_frame   = 1'b0;

        if (i_accept) begin
            unique case (r_phase)
                PH_ADDR: begin
                    n_addr  = r_addr | addr_lane;
                    n_sum   = r_sum + i_rx_byte;
                    n_count = count_inc;
                    if (count_inc >= 8'(ADDR_BYTES)) begin
                        n_phase = PH_HEAD2;
                    end
                end
                PH_HEAD2: begin
                    if (i_rx_byte != i_cfg.head_byte) begin
                        o_push.valid              = 1'b1;
                        o_push.data.result_kind   = KIND_REJECT;
                        o_push.data.error_code    = ERR_BAD_HEAD;
                        o_push.data.last_of_frame = 1'b1;
                        n_phase = PH_HUNT;
                    end else begin
                        n_sum   = r_sum + i_rx_byte;
                        n_phase = PH_CTRL;
                    end
                end
                PH_CTRL: begin
                    n_ctrl  = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len = i_rx_byte;
                    if (i_rx_byte > i_cfg.max_payload) begin
                        o_push.valid               = 1'b1;
                        o_push.data.result_kind    = KIND_REJECT;
                        o_push.data.payload_length = i_rx_byte;
                        o_push.data.error_code     = ERR_TOO_LONG;
                        o_push.data.last_of_frame  = 1'b1;
                        n_phase = PH_HUNT;
                    end else begin
                        n_sum   = r_sum + i_rx_byte;
                        n_count = '0;
                        n_phase = (i_rx_byte == 8'd0) ? PH_SUM : PH_PAY;
                    end
                end
                PH_PAY: begin
                    o_push.valid              = 1'b1;
                    o_push.data.payload_byte  = i_rx_byte - SCRAMBLE_BYTE;
                    o_push.data.payload_index = r_count;
                    n_sum   = r_sum + i_rx_byte;
                    n_count = count_inc;
                    if (count_inc >= r_len) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    if (i_rx_byte != r_sum) begin
                        o_push.valid              = 1'b1;
                        o_push.data.result_kind   = KIND_REJECT;
                        o_push.data.error_code    = ERR_CHECKSUM;
                        o_push.data.last_of_frame = 1'b1;
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    o_push.valid              = 1'b1;
                    o_push.data.last_of_frame = 1'b1;
                    if (i_rx_byte != i_cfg.tail_byte) begin
                        o_push.data.result_kind = KIND_REJECT;
                        o_push.data.error_code  = ERR_BAD_TAIL;
                    end else begin
                        o_push.data.result_kind = KIND_ACCEPT;
                    end
                    n_phase = PH_HUNT;
                end
                PH_HUNT: begin
                    // The preamble rule wins even when the head byte equals it.
                    if (i_rx_byte != PREAMBLE_BYTE && i_rx_byte == i_cfg.head_byte) begin
                        n_sum   = i_rx_byte;
                        n_count = '0;
                        n_addr  = '0;
                        n_ctrl  = '0;
                        n_len   = '0;
                        n_phase = PH_ADDR;
                    end
                end
            endcase
        end
    end

endmodule

// ----- rtl/mfd_out_buf.sv -----
// Two-entry result buffer that decouples the parser from the output channel.
module mfd_out_buf
    import mfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_push i_push,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_data
);

    t_result    r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;
    logic       pop;

    assign o_space = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign pop     = o_valid & i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push.valid;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_fill   = r_fill + {1'b0, i_push.valid} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

// ----- rtl/meter_frame_deframer.sv -----
// Top level of the meter frame deframer: register port, parser and result buffer.
//
// The block takes one received byte per item and returns payload items and one
// verdict item per frame. Each byte is handled by the parser state machine as it
// is accepted, so a byte can be accepted on every clock edge while the buffer has
// a free entry; the sustained rate is one item per cycle while the output takes
// results. Results go into a two-entry buffer, so a new byte is still taken while
// one finished result waits on the output side; the input only stalls when both
// entries are occupied. A result is held in the buffer from the cycle after the
// byte that causes it is accepted. Bytes seen while hunting for the head byte, and
// header bytes that pass their checks, produce no result. Configuration registers
// (head byte, tail byte, maximum payload length) sit at byte addresses 0, 4 and 8
// of the APB-style port and should only be written while the block is idle.
module meter_frame_deframer
    import mfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    mfd_rx_if.sink             i_rx,
    mfd_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       cfg_write;
    logic       buf_space;
    logic       rx_accept;
    t_res_push  push;
    t_result    res_data;

    // Register file. Writes complete in the access phase; pready never stalls.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte   <= HEAD_RESET;
            r_cfg.tail_byte   <= TAIL_RESET;
            r_cfg.max_payload <= MAX_PAY_RESET;
        end else if (cfg_write) begin
            if (reg_idx == REG_HEAD) begin
                r_cfg.head_byte <= pwdata[7:0];
            end
            if (reg_idx == REG_TAIL) begin
                r_cfg.tail_byte <= pwdata[7:0];
            end
            if (reg_idx == REG_MAX_PAY) begin
                r_cfg.max_payload <= pwdata[7:0];
            end
        end
    end

    // An unused register slot reads as zero.
    always_comb begin
        unique case (reg_idx)
            REG_HEAD:    prdata = {24'd0, r_cfg.head_byte};
            REG_TAIL:    prdata = {24'd0, r_cfg.tail_byte};
            REG_MAX_PAY: prdata = {24'd0, r_cfg.max_payload};
            default:     prdata = 32'd0;
        endcase
    end

    // A byte is taken whenever the result buffer has a free entry, since each
    // byte produces at most one result.
    assign i_rx.ready = buf_space;
    assign rx_accept  = i_rx.valid & buf_space;

    mfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx.rx_byte),
        .o_push    (push)
    );

    mfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (buf_space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (res_data)
    );

    assign o_res.result_kind    = res_data.result_kind;
    assign o_res.payload_byte   = res_data.payload_byte;
    assign o_res.payload_index  = res_data.payload_index;
    assign o_res.meter_address  = res_data.meter_address;
    assign o_res.control_code   = res_data.control_code;
    assign o_res.payload_length = res_data.payload_length;
    assign o_res.error_code     = res_data.error_code;
    assign o_res.last_of_frame  = res_data.last_of_frame;

endmodule

// ----- rtl/mfd_checker.sv -----
// Port-level checks for the meter frame deframer, bound to the top level.
module mfd_checker
    import mfd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_result_kind,
    input logic [7:0]  i_payload_byte,
    input logic [7:0]  i_payload_index,
    input logic [7:0]  i_payload_length,
    input logic [2:0]  i_error_code,
    input logic        i_last_of_frame,
    input logic        i_pready
);

    // Payload items never end a frame and carry no error.
    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_result_kind == KIND_PAYLOAD)
            |-> (!i_last_of_frame && i_error_code == ERR_NONE))
        else $error("payload item marked as verdict");

    // A payload item always lies inside the announced payload length.
    a_payload_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_result_kind == KIND_PAYLOAD)
            |-> (i_payload_index < i_payload_length))
        else $error("payload index beyond length");

    // Verdict kind agrees with its error code.
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_last_of_frame)
            |-> ((i_result_kind == KIND_ACCEPT && i_error_code == ERR_NONE) ||
                 (i_result_kind == KIND_REJECT && i_error_code != ERR_NONE)))
        else $error("verdict kind and error code disagree");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_result_kind) && $stable(i_payload_byte)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("register port stalled");

endmodule

bind meter_frame_deframer mfd_checker u_mfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_result_kind    (o_res.result_kind),
    .i_payload_byte   (o_res.payload_byte),
    .i_payload_index  (o_res.payload_index),
    .i_payload_length (o_res.payload_length),
    .i_error_code     (o_res.error_code),
    .i_last_of_frame  (o_res.last_of_frame),
    .i_pready         (pready)
);
